/* rtl/assert_macros.svh */
// Assertion macros shared by the page run allocator RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define PRU_ASSERT(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("pru assertion failed");

// When the antecedent holds, the consequent must hold in the same cycle.
`define PRU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pru assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define PRU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pru assertion failed");

`endif

/* rtl/pru_pkg.sv */
// Types and constants for the page run first fit allocator.
// No dependencies; imported by every module of the block.
package pru_pkg;

    localparam logic [31:0] REGION_BASE = 32'hc000_0000;
    localparam int          PAGE_SHIFT  = 12;
    localparam logic [7:0]  COUNT_MAX   = 8'd255;
    localparam int          COUNT_W     = 8;
    localparam int          NPAGE_W     = 13;
    localparam int          WIDE_W      = 20;

    localparam logic        OP_ALLOC = 1'b0;
    localparam logic        OP_REF   = 1'b1;

    localparam logic [1:0]  ST_OK       = 2'd0;
    localparam logic [1:0]  ST_NO_SPACE = 2'd1;
    localparam logic [1:0]  ST_RANGE    = 2'd2;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_BUMP,
        S_DONE
    } pru_state_t;

    typedef struct packed {
        logic               opcode;
        logic [NPAGE_W-1:0] page_count;
        logic [31:0]        virt_addr;
    } pru_req_t;

    typedef struct packed {
        logic [31:0] base_addr;
        logic [1:0]  status;
    } pru_rsp_t;

    typedef struct packed {
        logic               is_free;
        logic [COUNT_W-1:0] bumped;
    } pru_alu_t;

endpackage

/* rtl/page_run_first_fit_allocator.sv */
// Top level of the page run first fit allocator: sequencer, count memory and count unit.
// Depends on pru_pkg, pru_page_ram, pru_count_alu and assert_macros.svh.
//
//   channel | direction | handshake            | word
//   req     | in        | req_valid, req_ready | opcode, page_count, virt_addr
//   rsp     | out       | rsp_valid, rsp_ready | base_addr, status
//
// After reset an init pass sets every count, 1 for the first RESERVED_PAGES pages and 0 for
// the rest, before req_ready rises. An allocate scans one page count per cycle through the
// single memory read port until it finds the first free run of n pages, then bumps that run.
// A ref bumps its n counts by read-modify-write; range errors answer in the next cycle.
// One word is in flight at a time; rsp holds until rsp_ready, and req_ready rises after.
`include "assert_macros.svh"

module page_run_first_fit_allocator
    import pru_pkg::*;
#(
    parameter int NUM_PAGES      = 4096,
    parameter int RESERVED_PAGES = 768
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  pru_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output pru_rsp_t rsp
);

    localparam int CNT_W = $clog2(NUM_PAGES + 1);
    localparam int IDX_W = $clog2(NUM_PAGES);
    localparam logic [WIDE_W-1:0] NUM_WIDE  = WIDE_W'(NUM_PAGES);
    localparam logic [WIDE_W-1:0] RESV_WIDE = WIDE_W'(RESERVED_PAGES);
    localparam logic [CNT_W-1:0]  NUM_CNT   = CNT_W'(NUM_PAGES);

    pru_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   chk_idx_reg, chk_idx_next;
    logic               chk_valid_reg, chk_valid_next;
    logic [NPAGE_W-1:0] left_reg, left_next;
    logic [NPAGE_W-1:0] run_reg, run_next;
    logic [NPAGE_W-1:0] n_reg, n_next;
    logic [31:0]        base_reg, base_next;
    logic [1:0]         status_reg, status_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [COUNT_W-1:0] ram_wdata;
    logic               ram_re;
    logic [COUNT_W-1:0] ram_rdata;
    pru_alu_t           alu;

    logic [31:0]        ref_off;
    logic [WIDE_W-1:0]  ref_first;
    logic               alloc_bad;
    logic               ref_bad;
    logic               ref_empty;
    logic               scan_hit;
    logic               scan_miss;
    logic               init_last;
    logic               bump_done;
    logic [CNT_W-1:0]   hit_first;

    pru_page_ram #(
        .DEPTH  (NUM_PAGES),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    pru_count_alu u_alu (
        .count (ram_rdata),
        .res   (alu)
    );

    assign ref_off   = req.virt_addr - REGION_BASE;
    assign ref_first = WIDE_W'(ref_off >> PAGE_SHIFT);
    assign alloc_bad = (req.page_count == '0) || (WIDE_W'(req.page_count) > NUM_WIDE);
    assign ref_bad   = (req.virt_addr < REGION_BASE)
                       || ((ref_first + WIDE_W'(req.page_count)) > NUM_WIDE);
    assign ref_empty = (req.page_count == '0);
    assign scan_hit  = chk_valid_reg && alu.is_free && ((run_reg + NPAGE_W'(1)) == n_reg);
    assign scan_miss = !chk_valid_reg && (idx_reg == NUM_CNT);
    assign init_last = (idx_reg == NUM_CNT - CNT_W'(1));
    assign bump_done = (left_reg == '0) && !chk_valid_reg;
    assign hit_first = chk_idx_reg + CNT_W'(1) - CNT_W'(n_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.opcode == OP_ALLOC)
                    begin
                        state_next = alloc_bad ? S_DONE : S_SCAN;
                    end
                    else
                    begin
                        state_next = (ref_bad || ref_empty) ? S_DONE : S_BUMP;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = S_BUMP;
                end
                else if (scan_miss)
                begin
                    state_next = S_DONE;
                end
            end
            S_BUMP:
            begin
                if (bump_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        chk_idx_next   = idx_reg;
        chk_valid_next = 1'b0;
        left_next      = left_reg;
        run_next       = run_reg;
        n_next         = n_reg;
        base_next      = base_reg;
        status_next    = status_reg;
        ram_we         = 1'b0;
        ram_waddr      = chk_idx_reg[IDX_W-1:0];
        ram_wdata      = alu.bumped;
        ram_re         = 1'b0;
        req_ready      = 1'b0;
        rsp_valid      = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[IDX_W-1:0];
                ram_wdata = (WIDE_W'(idx_reg) < RESV_WIDE) ? COUNT_W'(1) : '0;
                idx_next  = idx_reg + CNT_W'(1);
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    n_next      = req.page_count;
                    left_next   = req.page_count;
                    run_next    = '0;
                    idx_next    = '0;
                    base_next   = '0;
                    status_next = ST_NO_SPACE;
                    if (req.opcode == OP_REF)
                    begin
                        if (ref_bad)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            status_next = ST_OK;
                            idx_next    = CNT_W'(ref_first);
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (idx_reg < NUM_CNT)
                begin
                    ram_re         = 1'b1;
                    chk_valid_next = 1'b1;
                    idx_next       = idx_reg + CNT_W'(1);
                end
                if (chk_valid_reg)
                begin
                    run_next = alu.is_free ? run_reg + NPAGE_W'(1) : '0;
                end
                if (scan_hit)
                begin
                    chk_valid_next = 1'b0;
                    idx_next       = hit_first;
                    left_next      = n_reg;
                    status_next    = ST_OK;
                    base_next      = REGION_BASE + (32'(hit_first) << PAGE_SHIFT);
                end
            end
            S_BUMP:
            begin
                if (left_reg != '0)
                begin
                    ram_re         = 1'b1;
                    chk_valid_next = 1'b1;
                    idx_next       = idx_reg + CNT_W'(1);
                    left_next      = left_reg - NPAGE_W'(1);
                end
                ram_we = chk_valid_reg;
            end
            S_DONE:
            begin
                rsp_valid = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign rsp.base_addr = base_reg;
    assign rsp.status    = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            idx_reg       <= '0;
            chk_valid_reg <= 1'b0;
            left_reg      <= '0;
            run_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            chk_valid_reg <= chk_valid_next;
            left_reg      <= left_next;
            run_reg       <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= chk_idx_next;
        n_reg       <= n_next;
        base_reg    <= base_next;
        status_reg  <= status_next;
    end

    `PRU_ASSERT_IMP(a_write_phase, ram_we, (state_reg == S_INIT) || (state_reg == S_BUMP))
    `PRU_ASSERT_IMP(a_run_below_n, state_reg == S_SCAN, run_reg < n_reg)
    `PRU_ASSERT_IMP(a_base_only_ok, rsp_valid && (rsp.base_addr != '0), rsp.status == ST_OK)
    `PRU_ASSERT_NXT(a_ready_after_rsp, rsp_valid && rsp_ready, req_ready)

endmodule

/* rtl/pru_count_alu.sv */
// Shared count unit: tests a page count for zero and forms its saturated increment.
// Depends on pru_pkg.
module pru_count_alu
    import pru_pkg::*;
(
    input  logic [COUNT_W-1:0] count,
    output pru_alu_t           res
);

    always_comb
    begin
        res.is_free = (count == '0);
        res.bumped  = (count == COUNT_MAX) ? COUNT_MAX : count + COUNT_W'(1);
    end

endmodule

/* rtl/pru_page_ram.sv */
// Single write port, single read port memory holding one count per page.
// Read data is registered. Depends on pru_pkg.
module pru_page_ram
    import pru_pkg::*;
#(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
)
(
    input  logic               clk,
    input  logic               we,
    input  logic [ADDR_W-1:0]  waddr,
    input  logic [COUNT_W-1:0] wdata,
    input  logic               re,
    input  logic [ADDR_W-1:0]  raddr,
    output logic [COUNT_W-1:0] rdata
);

    logic [COUNT_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
